[hw/rtl/civil_date_day_arithmetic_core_macros.svh]
// Assertion macros shared by the date arithmetic checker.
// Needs nothing; include by bare file name.
`ifndef CIVIL_DATE_DAY_ARITHMETIC_CORE_MACROS_SVH
`define CIVIL_DATE_DAY_ARITHMETIC_CORE_MACROS_SVH

// Check on every rising clock edge, masked while reset is asserted.
`define CDDA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every rising clock edge, reset included.
`define CDDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/cdda_pkg.sv]
// Constants, types and table functions of the civil date arithmetic core.
// No dependencies; used by the core and by its checker.
package cdda_pkg;

  localparam int MAX_YEAR = 9999;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OFF_W   = 23;
  localparam int CNT_W   = 24;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;

  localparam int YA_LSB  = 0;
  localparam int MA_LSB  = 14;
  localparam int DA_LSB  = 18;
  localparam int OFF_LSB = 23;
  localparam int YB_LSB  = 46;
  localparam int MB_LSB  = 60;
  localparam int DB_LSB  = 64;

  localparam logic OP_SHIFT = 1'b0;
  localparam logic OP_DIFF  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DATE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_RSVD     = 2'd3;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [YEAR_W:0] YEAR_LIM = (YEAR_W + 1)'(MAX_YEAR);

  // day counts since 0000-03-01 of 0001-01-01 and of MAX_YEAR-12-31
  localparam int CNT_LO = 306;
  localparam int CNT_HI = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                          + MAX_YEAR / 400 + 305;
  localparam logic signed [CNT_W:0] N_LO = (CNT_W + 1)'(CNT_LO);
  localparam logic signed [CNT_W:0] N_HI = (CNT_W + 1)'(CNT_HI);

  localparam logic signed [CNT_W:0] DIFF_MAX_S = 25'sd4194303;
  localparam logic signed [CNT_W:0] DIFF_MIN_S = -25'sd4194304;
  localparam logic signed [OFF_W-1:0] DIFF_MAX = 23'sh3FFFFF;
  localparam logic signed [OFF_W-1:0] DIFF_MIN = 23'sh400000;

  // reciprocals: floor(x/d) = (x*R) >> S over the ranges used here
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam logic [22:0] RECIP_146097 = 23'd7525902;
  localparam logic [17:0] RECIP_365    = 18'd183860;

  localparam logic [17:0] ERA_DAYS = 18'd146097;

  typedef struct packed {
    logic [YEAR_W-1:0] y;
    logic [YEAR_W-1:0] ym;
    logic [7:0]        qy;
    logic [7:0]        qym;
    logic [22:0]       y365;
    logic [8:0]        base;
    logic              ok;
    logic              feb29;
  } date_prep_t;

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] count;
  } date_cnt_t;

  typedef struct packed {
    logic                    op;
    logic [1:0]              status;
    logic signed [OFF_W-1:0] diff;
  } meta_t;

  // first day of a month counted from March 1
  function automatic logic [8:0] march_start(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    case (m)
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // same table indexed by month position, March first
  function automatic logic [8:0] mp_start(input logic [3:0] k);
    logic [8:0] r;
    case (k)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1:    r = 5'd31;
      4'd2:    r = 5'd28;
      4'd3:    r = 5'd31;
      4'd4:    r = 5'd30;
      4'd5:    r = 5'd31;
      4'd6:    r = 5'd30;
      4'd7:    r = 5'd31;
      4'd8:    r = 5'd31;
      4'd9:    r = 5'd30;
      4'd10:   r = 5'd31;
      4'd11:   r = 5'd30;
      4'd12:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // first half of the date to count step: range checks and products
  function automatic date_prep_t date_prep(input logic [YEAR_W-1:0] y,
                                           input logic [MONTH_W-1:0] m,
                                           input logic [DAY_W-1:0] d);
    date_prep_t p;
    logic [26:0] py;
    logic [26:0] pym;
    p.y     = y;
    p.ym    = (m <= MONTH_FEB) ? y - 14'd1 : y;
    py      = {13'b0, y} * {14'b0, RECIP_100};
    pym     = {13'b0, p.ym} * {14'b0, RECIP_100};
    p.qy    = py[26:19];
    p.qym   = pym[26:19];
    p.y365  = {9'b0, p.ym} * 23'd365;
    p.base  = march_start(m) + {4'b0, d} - 9'd1;
    p.feb29 = (m == MONTH_FEB) && (d == 5'd29);
    p.ok    = (y != '0) && ({1'b0, y} <= YEAR_LIM) && (m >= MONTH_JAN) &&
              (m <= MONTH_DEC) && (d != '0) && ((d <= month_days(m)) || p.feb29);
    return p;
  endfunction

  // second half: leap rule and day count since 0000-03-01
  function automatic date_cnt_t date_count(input date_prep_t p);
    date_cnt_t c;
    logic [14:0] q100x;
    logic        div4;
    logic        div100;
    logic        div400;
    logic        leap;
    q100x   = {7'b0, p.qy} * 15'd100;
    div4    = (p.y[1:0] == 2'b00);
    div100  = (q100x == {1'b0, p.y});
    div400  = div100 && (p.qy[1:0] == 2'b00);
    leap    = (div4 && !div100) || div400;
    c.ok    = p.ok && (!p.feb29 || leap);
    c.count = CNT_W'(p.y365) + CNT_W'(p.ym[YEAR_W-1:2]) - CNT_W'(p.qym)
              + CNT_W'(p.qym[7:2]) + CNT_W'(p.base);
    return c;
  endfunction

endpackage

[hw/rtl/civil_date_day_arithmetic_core.sv]
// Civil date arithmetic core: date shift by a day offset and date difference.
// Depends on cdda_pkg.
//
// Input channel in_*: one request per transfer. in_tuser is the opcode
// (0 shift date A by day_offset, 1 days from date B to date A). Dates are
// proleptic Gregorian and checked against month lengths and the leap rule.
// Output channel out_*: one result per request, in request order. out_tuser
// is the status (0 ok, 1 invalid input date, 2 result year out of range);
// unused fields read zero.
// Throughput is one request per cycle while the receiver keeps out_tready
// high, through the ten-stage pipeline, which spreads the reciprocal
// multiplications of the date conversions over stages 1, 4, 6 and 7.
// Each stage holds its item while the next stage is full and stalled, so a
// stalled receiver fills the pipeline before in_tready drops; bubbles are
// squeezed out. Synchronous reset empties the pipeline; payload registers
// are not reset.
module civil_date_day_arithmetic_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // year_a, month_a, day_a, day_offset, year_b, month_b, day_b, zero pad
  input  logic [cdda_pkg::IN_DATA_W-1:0]     in_tdata,
  // req_type
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // result_year, result_month, result_day, difference_days, zero pad
  output logic [cdda_pkg::OUT_DATA_W-1:0]    out_tdata,
  // status
  output logic [1:0]                         out_tuser
);
  import cdda_pkg::*;

  localparam int STAGES = 10;

  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] v_nxt;
  logic [STAGES-1:0] en;

  logic                 op0_r;
  logic [IN_DATA_W-1:0] data0_r;

  date_prep_t              d1_r   [2];
  date_prep_t              d1_nxt [2];
  logic                    op1_r;
  logic signed [OFF_W-1:0] off1_r;

  date_cnt_t               c2_r   [2];
  date_cnt_t               c2_nxt [2];
  logic                    op2_r;
  logic signed [OFF_W-1:0] off2_r;

  logic                    bad3;
  logic signed [CNT_W:0]   n_s3;
  logic signed [CNT_W:0]   diff_s3;
  meta_t                   m3_r;
  meta_t                   m3_nxt;
  logic [CNT_W-1:0]        n3_r;

  logic [46:0]      era_p4;
  meta_t            m4_r;
  logic [6:0]       era4_r;
  logic [CNT_W-1:0] n4_r;

  logic [CNT_W-1:0] doe_w5;
  meta_t            m5_r;
  logic [6:0]       era5_r;
  logic [17:0]      doe5_r;

  logic [35:0] q1460_p6;
  logic [2:0]  q36524_6;
  logic        q146096_6;
  meta_t       m6_r;
  logic [6:0]  era6_r;
  logic [17:0] doe6_r;
  logic [17:0] t6_r;
  logic [17:0] t6_nxt;

  logic [34:0] yoe_p7;
  meta_t       m7_r;
  logic [6:0]  era7_r;
  logic [17:0] doe7_r;
  logic [8:0]  yoe7_r;

  logic [17:0] yd_8;
  logic [1:0]  c100_8;
  meta_t       m8_r;
  logic [6:0]  era8_r;
  logic [8:0]  yoe8_r;
  logic [8:0]  doy8_r;
  logic [8:0]  doy8_nxt;

  logic [3:0]            mp9;
  logic [DAY_W-1:0]      dd9;
  logic [MONTH_W-1:0]    mm9;
  logic [15:0]           yy9;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [OUT_DATA_W-1:0] out_tdata_nxt;
  logic [1:0]            out_tuser_r;

  // stage advance: a stage loads when it is empty or its successor advances
  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || out_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
    v_nxt[0] = en[0] ? in_tvalid : v_r[0];
    for (int i = 1; i < STAGES; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[STAGES-1];
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (en[0]) begin
      op0_r   <= in_tuser[0];
      data0_r <= in_tdata;
    end
  end

  // stage 1: range checks, year products
  always_comb begin
    d1_nxt[0] = date_prep(data0_r[YA_LSB +: YEAR_W], data0_r[MA_LSB +: MONTH_W],
                          data0_r[DA_LSB +: DAY_W]);
    d1_nxt[1] = date_prep(data0_r[YB_LSB +: YEAR_W], data0_r[MB_LSB +: MONTH_W],
                          data0_r[DB_LSB +: DAY_W]);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_r[0] <= d1_nxt[0];
      d1_r[1] <= d1_nxt[1];
      op1_r   <= op0_r;
      off1_r  <= $signed(data0_r[OFF_LSB +: OFF_W]);
    end
  end

  // stage 2: leap rule, day counts
  always_comb begin
    c2_nxt[0] = date_count(d1_r[0]);
    c2_nxt[1] = date_count(d1_r[1]);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c2_r[0] <= c2_nxt[0];
      c2_r[1] <= c2_nxt[1];
      op2_r   <= op1_r;
      off2_r  <= off1_r;
    end
  end

  // stage 3: add offset or subtract counts, status
  always_comb begin
    bad3    = !c2_r[0].ok || ((op2_r == OP_DIFF) && !c2_r[1].ok);
    n_s3    = $signed({1'b0, c2_r[0].count}) + $signed({{2{off2_r[OFF_W-1]}}, off2_r});
    diff_s3 = $signed({1'b0, c2_r[0].count}) - $signed({1'b0, c2_r[1].count});
    m3_nxt.op     = op2_r;
    m3_nxt.status = ST_OK;
    m3_nxt.diff   = '0;
    if (bad3) begin
      m3_nxt.status = ST_BAD_DATE;
    end else if (op2_r == OP_SHIFT) begin
      if ((n_s3 < N_LO) || (n_s3 > N_HI)) begin
        m3_nxt.status = ST_RANGE;
      end
    end else if (diff_s3 > DIFF_MAX_S) begin
      m3_nxt.diff = DIFF_MAX;
    end else if (diff_s3 < DIFF_MIN_S) begin
      m3_nxt.diff = DIFF_MIN;
    end else begin
      m3_nxt.diff = diff_s3[OFF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      m3_r <= m3_nxt;
      n3_r <= n_s3[CNT_W-1:0];
    end
  end

  // stage 4: era = n / 146097
  assign era_p4 = {23'b0, n3_r} * {24'b0, RECIP_146097};

  always_ff @(posedge clk) begin
    if (en[4]) begin
      m4_r   <= m3_r;
      era4_r <= era_p4[46:40];
      n4_r   <= n3_r;
    end
  end

  // stage 5: day of era
  assign doe_w5 = n4_r - CNT_W'({11'b0, era4_r} * {7'b0, ERA_DAYS});

  always_ff @(posedge clk) begin
    if (en[5]) begin
      m5_r   <= m4_r;
      era5_r <= era4_r;
      doe5_r <= doe_w5[17:0];
    end
  end

  // stage 6: leap-day corrected day of era
  always_comb begin
    q1460_p6  = {18'b0, doe5_r} * {18'b0, RECIP_365};
    q146096_6 = (doe5_r >= 18'd146096);
    q36524_6  = {2'b0, (doe5_r >= 18'd36524)} + {2'b0, (doe5_r >= 18'd73048)}
                + {2'b0, (doe5_r >= 18'd109572)} + {2'b0, q146096_6};
    t6_nxt    = doe5_r - {10'b0, q1460_p6[35:28]} + {15'b0, q36524_6}
                - {17'b0, q146096_6};
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      m6_r   <= m5_r;
      era6_r <= era5_r;
      doe6_r <= doe5_r;
      t6_r   <= t6_nxt;
    end
  end

  // stage 7: year of era
  assign yoe_p7 = {17'b0, t6_r} * {17'b0, RECIP_365};

  always_ff @(posedge clk) begin
    if (en[7]) begin
      m7_r   <= m6_r;
      era7_r <= era6_r;
      doe7_r <= doe6_r;
      yoe7_r <= yoe_p7[34:26];
    end
  end

  // stage 8: day of March-based year
  always_comb begin
    c100_8   = {1'b0, (yoe7_r >= 9'd100)} + {1'b0, (yoe7_r >= 9'd200)}
               + {1'b0, (yoe7_r >= 9'd300)};
    yd_8     = {9'b0, yoe7_r} * 18'd365 + {11'b0, yoe7_r[8:2]} - {16'b0, c100_8};
    doy8_nxt = 9'(doe7_r - yd_8);
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      m8_r   <= m7_r;
      era8_r <= era7_r;
      yoe8_r <= yoe7_r;
      doy8_r <= doy8_nxt;
    end
  end

  // stage 9: month, day, year; output register
  always_comb begin
    mp9 = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy8_r >= mp_start(4'(k))) begin
        mp9 = 4'(k);
      end
    end
    dd9 = 5'(doy8_r - mp_start(mp9) + 9'd1);
    mm9 = (mp9 < 4'd10) ? mp9 + 4'd3 : mp9 - 4'd9;
    yy9 = {7'b0, yoe8_r} + {9'b0, era8_r} * 16'd400
          + ((mm9 <= MONTH_FEB) ? 16'd1 : 16'd0);
    out_tdata_nxt = '0;
    if ((m8_r.status == ST_OK) && (m8_r.op == OP_SHIFT)) begin
      out_tdata_nxt[YEAR_W-1:0]       = yy9[YEAR_W-1:0];
      out_tdata_nxt[MA_LSB +: MONTH_W] = mm9;
      out_tdata_nxt[DA_LSB +: DAY_W]   = dd9;
    end else begin
      out_tdata_nxt[OFF_LSB +: OFF_W] = m8_r.diff;
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= m8_r.status;
    end
  end

endmodule

[hw/rtl/cdda_checker.sv]
// Port-level assertions for the civil date arithmetic core, bound to its top.
// Depends on cdda_pkg and civil_date_day_arithmetic_core_macros.svh.
`include "civil_date_day_arithmetic_core_macros.svh"

module cdda_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cdda_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser
);
  import cdda_pkg::*;

  `CDDA_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_tvalid, "result offered after reset")
  `CDDA_ASSERT(a_result_held, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")
  `CDDA_ASSERT(a_status_code, clk, rst_n, out_tvalid |-> out_tuser != ST_RSVD, "reserved status code")
  `CDDA_ASSERT(a_fail_zero, clk, rst_n, out_tvalid && out_tuser != ST_OK |-> out_tdata == '0, "fields set on failed request")
  `CDDA_ASSERT(a_one_kind, clk, rst_n, out_tvalid && out_tdata[17:14] != 4'd0 |-> out_tdata[45:23] == 23'd0, "date and difference both set")

endmodule

bind civil_date_day_arithmetic_core cdda_checker u_cdda_checker (.*);
